### hdl/emx_pkg.sv
`timescale 1ns / 1ps

package emx_pkg;

	// Field and datapath widths
	localparam int REG_W    = 31;
	localparam int MOD_BITS = 31;
	localparam int EXP_BITS = 31;
	localparam int T_W      = MOD_BITS + 2;
	localparam int UCNT_W   = $clog2(REG_W + 1);
	localparam int ECNT_W   = $clog2(EXP_BITS);

	// Actions
	localparam logic [1:0] ACT_ENC    = 2'd0;
	localparam logic [1:0] ACT_DEC    = 2'd1;
	localparam logic [1:0] ACT_RER    = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Register indexes
	localparam logic [1:0] REG_MODULUS = 2'd0;
	localparam logic [1:0] REG_GEN     = 2'd1;
	localparam logic [1:0] REG_PUB     = 2'd2;
	localparam logic [1:0] REG_PRIV    = 2'd3;

	// Shared unit operations
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic go;
		logic op;
	} emx_cmd_t;

endpackage

### hdl/emx_unit.sv
`timescale 1ns / 1ps

// Shared shift unit: modular multiply (opa * opb mod p, opb < p) or
// divide (opa / opb, with remainder), one bit of opa per cycle, MSB first.
module emx_unit import emx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  emx_cmd_t            cmd,
	input  logic [REG_W-1:0]    opa,
	input  logic [MOD_BITS-1:0] opb,
	input  logic [MOD_BITS-1:0] p,
	output logic                done,
	output logic [MOD_BITS-1:0] res,
	output logic [MOD_BITS-1:0] rem
);

	logic                run_q;
	logic                op_q;
	logic                done_q;
	logic [UCNT_W-1:0]   cnt_q;
	logic [REG_W-1:0]    sh_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] quo_q;
	logic                bit_in;
	logic [T_W-1:0]      t;
	logic [T_W-1:0]      t_nxt;
	logic                q_bit;

	assign bit_in = sh_q[REG_W-1];

	// One shift-add-reduce or shift-subtract step
	always_comb begin
		q_bit = 1'b0;
		if (op_q == OP_MUL) begin
			t = T_W'({acc_q, 1'b0}) + (bit_in ? T_W'(opb) : T_W'(0));
			if (t >= T_W'({p, 1'b0})) begin
				t_nxt = t - T_W'({p, 1'b0});
			end else if (t >= T_W'(p)) begin
				t_nxt = t - T_W'(p);
			end else begin
				t_nxt = t;
			end
		end else begin
			t = T_W'({acc_q, bit_in});
			if (t >= T_W'(opb)) begin
				t_nxt = t - T_W'(opb);
				q_bit = 1'b1;
			end else begin
				t_nxt = t;
			end
		end
	end

	// Advance the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				run_q <= 1'b1;
				op_q  <= cmd.op;
				cnt_q <= UCNT_W'(REG_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == UCNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd.go) begin
			sh_q  <= opa;
			acc_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			sh_q  <= {sh_q[REG_W-2:0], 1'b0};
			acc_q <= t_nxt[MOD_BITS-1:0];
			quo_q <= {quo_q[MOD_BITS-2:0], q_bit};
		end
	end

	assign done = done_q;
	assign res  = (op_q == OP_MUL) ? acc_q : quo_q;
	assign rem  = acc_q;

endmodule

### hdl/emx_seq.sv
`timescale 1ns / 1ps

// Sequencer: reductions, square-and-multiply and extended Euclid on the shared unit.
module emx_seq import emx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          action,
	input  logic [REG_W-1:0]    first_value,
	input  logic [REG_W-1:0]    second_value,
	input  logic [REG_W-1:0]    exponent,
	input  logic [MOD_BITS-1:0] p,
	input  logic [REG_W-1:0]    gen,
	input  logic [REG_W-1:0]    pub,
	input  logic [REG_W-1:0]    priv,
	output logic                busy,
	output logic                done,
	output logic [REG_W-1:0]    out_first,
	output logic [REG_W-1:0]    out_second,
	output logic                status
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_REDA  = 4'd1;
	localparam logic [3:0] S_REDB  = 4'd2;
	localparam logic [3:0] S_BASE  = 4'd3;
	localparam logic [3:0] S_PSTEP = 4'd4;
	localparam logic [3:0] S_PMUL  = 4'd5;
	localparam logic [3:0] S_PSQ   = 4'd6;
	localparam logic [3:0] S_PEND  = 4'd7;
	localparam logic [3:0] S_POST  = 4'd8;
	localparam logic [3:0] S_ECHK  = 4'd9;
	localparam logic [3:0] S_DIV   = 4'd10;
	localparam logic [3:0] S_TMUL  = 4'd11;
	localparam logic [3:0] S_FINAL = 4'd12;

	logic [3:0]          state_q;
	emx_cmd_t            cmd_q;
	logic [REG_W-1:0]    opa_q;
	logic [MOD_BITS-1:0] opb_q;
	logic [1:0]          act_q;
	logic                pass_q;
	logic [REG_W-1:0]    second_q;
	logic [REG_W-1:0]    exp_in_q;
	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] sq_q;
	logic [EXP_BITS-1:0] ex_q;
	logic [ECNT_W-1:0]   ecnt_q;
	logic [MOD_BITS-1:0] e0_q;
	logic [MOD_BITS-1:0] e1_q;
	logic [MOD_BITS-1:0] t0_q;
	logic [MOD_BITS-1:0] t1_q;
	logic [MOD_BITS-1:0] rem_q;
	logic                done_q;
	logic [REG_W-1:0]    out_first_q;
	logic [REG_W-1:0]    out_second_q;
	logic                status_q;
	logic                u_done;
	logic [MOD_BITS-1:0] u_res;
	logic [MOD_BITS-1:0] u_rem;
	logic [MOD_BITS-1:0] t_new;

	emx_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_q),
		.opa    (opa_q),
		.opb    (opb_q),
		.p      (p),
		.done   (u_done),
		.res    (u_res),
		.rem    (u_rem)
	);

	// Next Bezout coefficient mod p: t0 - q*t1
	assign t_new = (t0_q >= u_res) ? (t0_q - u_res) : (t0_q + (p - u_res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= '0;
			done_q   <= 1'b0;
			pass_q   <= 1'b0;
			act_q    <= ACT_ENC;
			status_q <= 1'b0;
		end else begin
			cmd_q  <= '0;
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q    <= action;
						second_q <= second_value;
						exp_in_q <= exponent;
						pass_q   <= 1'b0;
						if (p < MOD_BITS'(2) || action == ACT_UNUSED) begin
							out_first_q  <= '0;
							out_second_q <= '0;
							status_q     <= 1'b0;
							done_q       <= 1'b1;
						end else begin
							cmd_q   <= '{go: 1'b1, op: OP_MUL};
							opa_q   <= first_value;
							opb_q   <= MOD_BITS'(1);
							state_q <= S_REDA;
						end
					end
				end
				S_REDA: begin
					if (u_done) begin
						a_q     <= u_res;
						cmd_q   <= '{go: 1'b1, op: OP_MUL};
						opa_q   <= second_q;
						state_q <= S_REDB;
					end
				end
				S_REDB: begin
					if (u_done) begin
						b_q     <= u_res;
						cmd_q   <= '{go: 1'b1, op: OP_MUL};
						opa_q   <= (act_q == ACT_DEC) ? REG_W'(a_q) : gen;
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					if (u_done) begin
						sq_q    <= u_res;
						acc_q   <= MOD_BITS'(1);
						ecnt_q  <= '0;
						ex_q    <= (act_q == ACT_DEC && !pass_q) ?
							EXP_BITS'(priv) : EXP_BITS'(exp_in_q);
						state_q <= S_PSTEP;
					end
				end
				S_PSTEP: begin
					cmd_q <= '{go: 1'b1, op: OP_MUL};
					opa_q <= REG_W'(sq_q);
					opb_q <= ex_q[0] ? acc_q : sq_q;
					state_q <= ex_q[0] ? S_PMUL : S_PSQ;
				end
				S_PMUL: begin
					if (u_done) begin
						acc_q   <= u_res;
						cmd_q   <= '{go: 1'b1, op: OP_MUL};
						opb_q   <= sq_q;
						state_q <= S_PSQ;
					end
				end
				S_PSQ: begin
					if (u_done) begin
						sq_q   <= u_res;
						ex_q   <= ex_q >> 1;
						ecnt_q <= ecnt_q + 1'b1;
						state_q <= (ecnt_q == ECNT_W'(EXP_BITS - 1)) ? S_PEND : S_PSTEP;
					end
				end
				S_PEND: begin
					if (act_q == ACT_DEC) begin
						e0_q    <= p;
						e1_q    <= acc_q;
						t0_q    <= '0;
						t1_q    <= MOD_BITS'(1);
						state_q <= S_ECHK;
					end else if (act_q == ACT_ENC && !pass_q) begin
						out_first_q <= REG_W'(acc_q);
						pass_q      <= 1'b1;
						cmd_q       <= '{go: 1'b1, op: OP_MUL};
						opa_q       <= pub;
						opb_q       <= MOD_BITS'(1);
						state_q     <= S_BASE;
					end else begin
						cmd_q   <= '{go: 1'b1, op: OP_MUL};
						opa_q   <= (act_q == ACT_RER && pass_q) ? REG_W'(b_q) : REG_W'(a_q);
						opb_q   <= acc_q;
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (u_done) begin
						if (!pass_q) begin
							out_first_q <= REG_W'(u_res);
							pass_q      <= 1'b1;
							cmd_q       <= '{go: 1'b1, op: OP_MUL};
							opa_q       <= pub;
							opb_q       <= MOD_BITS'(1);
							state_q     <= S_BASE;
						end else begin
							out_second_q <= REG_W'(u_res);
							status_q     <= 1'b0;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end
					end
				end
				S_ECHK: begin
					if (e1_q == '0) begin
						if (e0_q == MOD_BITS'(1)) begin
							cmd_q   <= '{go: 1'b1, op: OP_MUL};
							opa_q   <= REG_W'(b_q);
							opb_q   <= t0_q;
							state_q <= S_FINAL;
						end else begin
							// No inverse: return (-c2) mod p and flag it
							out_first_q  <= (b_q == '0) ? '0 : REG_W'(p - b_q);
							out_second_q <= '0;
							status_q     <= 1'b1;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end
					end else begin
						cmd_q   <= '{go: 1'b1, op: OP_DIV};
						opa_q   <= REG_W'(e0_q);
						opb_q   <= e1_q;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (u_done) begin
						rem_q   <= u_rem;
						cmd_q   <= '{go: 1'b1, op: OP_MUL};
						opa_q   <= REG_W'(u_res);
						opb_q   <= t1_q;
						state_q <= S_TMUL;
					end
				end
				S_TMUL: begin
					if (u_done) begin
						e0_q    <= e1_q;
						e1_q    <= rem_q;
						t0_q    <= t1_q;
						t1_q    <= t_new;
						state_q <= S_ECHK;
					end
				end
				S_FINAL: begin
					if (u_done) begin
						out_first_q  <= REG_W'(u_res);
						out_second_q <= '0;
						status_q     <= 1'b0;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign out_first  = out_first_q;
	assign out_second = out_second_q;
	assign status     = status_q;

endmodule

### hdl/elgamal_modexp_engine.sv
`timescale 1ns / 1ps

// ElGamal engine: one item at a time, taken when start is high and busy low.
// Every step runs on one shared shift unit that handles one bit per cycle.
// Encrypt and rerandomize take four reductions, two 31-bit exponentiations of
// up to 62 multiplies each and up to two final multiplies; decrypt takes three
// reductions, one exponentiation plus up to about 45 Euclid steps of two unit
// runs each. A degenerate modulus or an unused action finishes straight from
// idle, without busy rising. The result shows for exactly one cycle with done
// high; the receiver cannot stall it, and busy drops on that cycle.
module elgamal_modexp_engine import emx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       action,
	input  logic [REG_W-1:0] first_value,
	input  logic [REG_W-1:0] second_value,
	input  logic [REG_W-1:0] exponent,
	output logic             done,
	output logic [REG_W-1:0] out_first,
	output logic [REG_W-1:0] out_second,
	output logic             status,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [REG_W-1:0] cfg_wdata
);

	logic [MOD_BITS-1:0] modulus_q;
	logic [REG_W-1:0]    gen_q;
	logic [REG_W-1:0]    pub_q;
	logic [REG_W-1:0]    priv_q;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_BITS'(467);
			gen_q     <= REG_W'(2);
			pub_q     <= '0;
			priv_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MODULUS: modulus_q <= cfg_wdata[MOD_BITS-1:0];
				REG_GEN:     gen_q     <= cfg_wdata;
				REG_PUB:     pub_q     <= cfg_wdata;
				REG_PRIV:    priv_q    <= cfg_wdata;
				default:     modulus_q <= modulus_q;
			endcase
		end
	end

	emx_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.first_value  (first_value),
		.second_value (second_value),
		.exponent     (exponent),
		.p            (modulus_q),
		.gen          (gen_q),
		.pub          (pub_q),
		.priv         (priv_q),
		.busy         (busy),
		.done         (done),
		.out_first    (out_first),
		.out_second   (out_second),
		.status       (status)
	);

endmodule
